// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define CHK_ON_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define CHK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dsrd_pkg.sv =====
`default_nettype none
package dsrd_pkg;

  // Field and datapath widths
  localparam int AXW = 16;   // raw axis
  localparam int QW  = 15;   // scaled magnitude, one search step per bit
  localparam int RW  = 15;   // dead-zone radius
  localparam int R2W = 30;   // squared radius
  localparam int M2W = 32;   // squared stick magnitude
  localparam int PW  = 31;   // |a| * full scale
  localparam int P2W = 60;   // (|a| * full scale)^2
  localparam int SW  = 62;   // q^2 * m2 during the search
  localparam int AW  = 47;   // q * m2 during the search

  localparam int FULL_SCALE_DEF = 32767;
  localparam logic [RW-1:0] LEFT_RADIUS_RST  = 15'd7849;
  localparam logic [RW-1:0] RIGHT_RADIUS_RST = 15'd8689;

  // Register index within the configuration space
  typedef enum logic {
    REG_LEFT_RADIUS  = 1'b0,
    REG_RIGHT_RADIUS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [AXW-1:0] left_x;
    logic signed [AXW-1:0] left_y;
    logic signed [AXW-1:0] right_x;
    logic signed [AXW-1:0] right_y;
  } in_word_t;

  typedef struct packed {
    logic signed [AXW-1:0] out_left_x;
    logic signed [AXW-1:0] out_left_y;
    logic signed [AXW-1:0] out_right_x;
    logic signed [AXW-1:0] out_right_y;
  } out_word_t;

  // What one lane reports to the merge stage
  typedef struct packed {
    logic                  active;
    logic signed [AXW-1:0] x;
    logic signed [AXW-1:0] y;
  } stick_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dsrd_root.sv =====
`default_nettype none
// Pipelined search for the largest q with q^2 * m2 <= p2, one bit per stage.
module dsrd_root
  import dsrd_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [M2W-1:0] m2_in,
  input  wire logic [P2W-1:0] p2_in,
  output logic      [QW-1:0]  q
);

  logic [M2W-1:0] m2_r [0:QW-1];
  logic [P2W-1:0] p2_r [0:QW-1];
  logic [SW-1:0]  s_r  [0:QW-1];
  logic [AW-1:0]  a_r  [0:QW-1];
  logic [QW-1:0]  q_r  [0:QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [M2W-1:0] m2_c;
    logic [P2W-1:0] p2_c;
    logic [SW-1:0]  s_c;
    logic [AW-1:0]  a_c;
    logic [QW-1:0]  q_c;
    logic [SW-1:0]  trial;
    logic           take;

    if (k == 0) begin : g_first
      assign m2_c = m2_in;
      assign p2_c = p2_in;
      assign s_c  = '0;
      assign a_c  = '0;
      assign q_c  = '0;
    end else begin : g_next
      assign m2_c = m2_r[k-1];
      assign p2_c = p2_r[k-1];
      assign s_c  = s_r[k-1];
      assign a_c  = a_r[k-1];
      assign q_c  = q_r[k-1];
    end

    // (q + 2^B)^2 * m2 = q^2*m2 + 2^(B+1)*q*m2 + 2^(2B)*m2
    assign trial = s_c + (SW'(a_c) << (B + 1)) + (SW'(m2_c) << (2 * B));
    assign take  = (trial <= SW'(p2_c));

    // Advance one step; keep the trial bit when it still fits
    always_ff @(posedge clk) begin
      if (en) begin
        m2_r[k] <= m2_c;
        p2_r[k] <= p2_c;
        if (take) begin
          s_r[k] <= trial;
          a_r[k] <= a_c + (AW'(m2_c) << B);
          q_r[k] <= q_c | (QW'(1) << B);
        end else begin
          s_r[k] <= s_c;
          a_r[k] <= a_c;
          q_r[k] <= q_c;
        end
      end
    end
  end

  assign q = q_r[QW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/dsrd_lane.sv =====
`default_nettype none
// Condition one stick: squared magnitude, dead-zone test, radial clamp.
module dsrd_lane
  import dsrd_pkg::*;
#(
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [AXW-1:0] x,
  input  wire logic signed [AXW-1:0] y,
  input  wire logic        [R2W-1:0] r2,
  output stick_t                     res
);

  localparam logic [RW-1:0]  FS  = RW'(FULL_SCALE);
  localparam logic [M2W-1:0] FS2 = M2W'(FULL_SCALE * FULL_SCALE);

  // Stage 1: magnitudes
  logic        [AXW-1:0] ax1, ay1;
  logic signed [AXW-1:0] x1, y1;
  // Stage 2: squares and scaled magnitudes
  logic        [M2W-1:0] xx2, yy2;
  logic        [PW-1:0]  px2, py2;
  logic signed [AXW-1:0] x2, y2;
  // Stage 3: squared magnitude and squared scaled axes
  logic        [M2W-1:0] m23;
  logic        [P2W-1:0] pxx3, pyy3;
  logic signed [AXW-1:0] x3, y3;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1  <= x[AXW-1] ? AXW'(~x + 1'b1) : AXW'(x);
      ay1  <= y[AXW-1] ? AXW'(~y + 1'b1) : AXW'(y);
      x1   <= x;
      y1   <= y;
      xx2  <= M2W'(ax1) * M2W'(ax1);
      yy2  <= M2W'(ay1) * M2W'(ay1);
      px2  <= PW'(ax1) * PW'(FS);
      py2  <= PW'(ay1) * PW'(FS);
      x2   <= x1;
      y2   <= y1;
      m23  <= xx2 + yy2;
      pxx3 <= P2W'(px2) * P2W'(px2);
      pyy3 <= P2W'(py2) * P2W'(py2);
      x3   <= x2;
      y3   <= y2;
    end
  end

  logic [QW-1:0] qx, qy;

  dsrd_root u_root_x (.clk(clk), .en(en), .m2_in(m23), .p2_in(pxx3), .q(qx));
  dsrd_root u_root_y (.clk(clk), .en(en), .m2_in(m23), .p2_in(pyy3), .q(qy));

  // Carry raw axes and magnitude alongside the search
  logic        [M2W-1:0] dm2 [0:QW-1];
  logic signed [AXW-1:0] dx  [0:QW-1];
  logic signed [AXW-1:0] dy  [0:QW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dm2[0] <= m23;
      dx[0]  <= x3;
      dy[0]  <= y3;
      for (int i = 1; i < QW; i++) begin
        dm2[i] <= dm2[i-1];
        dx[i]  <= dx[i-1];
        dy[i]  <= dy[i-1];
      end
    end
  end

  logic [M2W-1:0] m2f;
  logic           dead, clamp;
  logic signed [AXW-1:0] sx, sy;

  assign m2f   = dm2[QW-1];
  assign dead  = (m2f < M2W'(r2));
  assign clamp = (m2f > FS2);
  assign sx    = dx[QW-1][AXW-1] ? -$signed(AXW'(qx)) : $signed(AXW'(qx));
  assign sy    = dy[QW-1][AXW-1] ? -$signed(AXW'(qy)) : $signed(AXW'(qy));

  // Pick zero, clamped or raw pair
  always_comb begin
    res.active = (m2f > M2W'(r2));
    if (dead) begin
      res.x = '0;
      res.y = '0;
    end else if (clamp) begin
      res.x = sx;
      res.y = sy;
    end else begin
      res.x = dx[QW-1];
      res.y = dy[QW-1];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dual_stick_radial_deadzone.sv =====
// Throughput: one word per cycle while the output is not stalled; each stick has its own
// lane with a 15-stage bit-per-stage root/divide search, fed by three front stages
// (absolute value, products). Words where neither stick leaves its dead zone produce no
// output. Reset (rst, synchronous): empties the pipeline, radii return to 7849 and 8689.
`default_nettype none
module dual_stick_radial_deadzone
  import dsrd_pkg::*;
#(
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LAT = 3 + QW;

  logic [RW-1:0]  left_radius, right_radius;
  logic [R2W-1:0] left_r2, right_r2;
  reg_idx_t       widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[2]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      left_radius  <= LEFT_RADIUS_RST;
      right_radius <= RIGHT_RADIUS_RST;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_LEFT_RADIUS:  left_radius  <= pwdata[RW-1:0];
        REG_RIGHT_RADIUS: right_radius <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // Squared radii, refreshed every cycle
  always_ff @(posedge clk) begin
    left_r2  <= R2W'(left_radius) * R2W'(left_radius);
    right_r2 <= R2W'(right_radius) * R2W'(right_radius);
  end

  always_comb begin
    case (widx)
      REG_LEFT_RADIUS:  prdata = 32'(left_radius);
      REG_RIGHT_RADIUS: prdata = 32'(right_radius);
      default:          prdata = '0;
    endcase
  end

  // Pipeline advances whenever the output register can take a word
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [LAT-1:0] vp;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (adv) begin
      vp <= {vp[LAT-2:0], in_valid};
    end
  end

  stick_t lres, rres;

  dsrd_lane #(.FULL_SCALE(FULL_SCALE)) u_lane_l (
    .clk(clk), .en(adv), .x(in_data.left_x), .y(in_data.left_y),
    .r2(left_r2), .res(lres)
  );

  dsrd_lane #(.FULL_SCALE(FULL_SCALE)) u_lane_r (
    .clk(clk), .en(adv), .x(in_data.right_x), .y(in_data.right_y),
    .r2(right_r2), .res(rres)
  );

  // Merge lanes; drop words with both sticks inside the dead zone
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vp[LAT-1] && (lres.active || rres.active);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_left_x  <= lres.x;
      out_data.out_left_y  <= lres.y;
      out_data.out_right_x <= rres.x;
      out_data.out_right_y <= rres.y;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dsrd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module dsrd_checker
  import dsrd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  logic stall, in_range;

  assign stall    = out_valid && !out_ready;
  assign in_range = out_data.out_left_x != 16'sh8000 && out_data.out_left_y != 16'sh8000 &&
                    out_data.out_right_x != 16'sh8000 && out_data.out_right_y != 16'sh8000;

  // Output word holds while stalled
  `CHK_ON_CLK(a_out_hold, clk, rst, stall |=> out_valid, "out word dropped")
  `CHK_ON_CLK(a_out_stable, clk, rst, stall |=> $stable(out_data), "out word changed")
  // Input side stalls only behind a stalled output
  `CHK_ON_CLK(a_in_stall, clk, rst, !in_ready |-> stall, "input stalled")
  // Nothing leaves right after reset
  `CHK_ALWAYS(a_rst_empty, clk, $past(rst) |-> !out_valid, "output after reset")
  // Outputs stay within full scale
  `CHK_ON_CLK(a_range, clk, rst, out_valid |-> in_range, "value out of range")

endmodule

bind dual_stick_radial_deadzone dsrd_checker u_dsrd_checker (.*);
`default_nettype wire
